@@ hw/rtl/wait_for_graph_cycle_detect_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the wait-for graph cycle detector
// Each macro samples on aclk and is disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef WAIT_FOR_GRAPH_CYCLE_DETECT_ASSERT_SVH
`define WAIT_FOR_GRAPH_CYCLE_DETECT_ASSERT_SVH

// condition holds at every edge out of reset
`define WFGCD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication
`define WFGCD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WFGCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/wfgcd_pkg.sv @@
// ----------------------------------------------------------------------------
// wfgcd_pkg
// Shared sizes and controller/datapath interface types of the cycle detector.
// ----------------------------------------------------------------------------
package wfgcd_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = 4;   // bits of a node index
    localparam int CNT_W     = 5;   // bits of a count 0..MAX_NODES

    typedef logic [NODE_W-1:0]    node_t;
    typedef logic [MAX_NODES-1:0] mask_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef struct packed {
        logic load_row;     // write the accepted row into the matrix
        logic search_init;  // reset root index and found flag
        logic root_inc;     // move on to the next root
        logic push_root;    // push the current root onto the path
        logic step;         // probe one edge of the node on top of the path
        logic publish;      // load the output register and clear the graph
    } wfgcd_cmd_t;

    typedef struct packed {
        logic root_end;     // root index reached the live node count
        logic root_visited; // current root already visited
        logic path_empty;   // path stack is empty
        logic hit;          // probed edge closes a cycle
        logic out_full;     // output register still holds an untaken word
    } wfgcd_status_t;

endpackage

@@ hw/rtl/wfgcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// wfgcd_ctrl
// Sequencer: row loading, root scan, depth-first search steps, result hand-off.
// ----------------------------------------------------------------------------
module wfgcd_ctrl
    import wfgcd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tlast,
    output logic          s_tready,
    input  wfgcd_status_t status,
    output wfgcd_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_row = 1'b1;
                    if (s_tlast) begin
                        cmd.search_init = 1'b1;
                        state_next      = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                priority if (status.root_end) begin
                    state_next = ST_DONE;
                end else if (status.root_visited) begin
                    cmd.root_inc = 1'b1;
                end else begin
                    cmd.push_root = 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_STEP: begin
                if (status.path_empty) begin
                    cmd.root_inc = 1'b1;
                    state_next   = ST_ROOT;
                end else begin
                    cmd.step = 1'b1;
                    if (status.hit) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!status.out_full) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/wfgcd_dp.sv @@
// ----------------------------------------------------------------------------
// wfgcd_dp
// Datapath: adjacency rows, visit and path marks, path stack, output register.
// ----------------------------------------------------------------------------
module wfgcd_dp
    import wfgcd_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  wfgcd_cmd_t    cmd,
    output wfgcd_status_t status,
    input  node_t         row_node,
    input  mask_t         row_edges,
    input  cnt_t          node_count,
    input  logic          m_tready,
    output logic          m_tvalid,
    output logic          cycle_found
);

    mask_t adj_reg [MAX_NODES];
    mask_t visited_reg;
    mask_t on_path_reg;
    node_t node_stack_reg [MAX_NODES];
    cnt_t  next_stack_reg [MAX_NODES];
    cnt_t  depth_reg;
    cnt_t  root_reg;
    logic  found_reg;
    logic  out_valid_reg;
    logic  out_data_reg;

    cnt_t  live_n;
    cnt_t  depth_m1;
    node_t top_idx;
    node_t push_idx;
    node_t top_node;
    cnt_t  probe;
    node_t probe_node;
    node_t root_node;
    logic  probe_end;
    logic  probe_edge;
    logic  push_ok;
    logic  push_child;

    assign live_n     = (node_count > cnt_t'(MAX_NODES)) ? cnt_t'(MAX_NODES) : node_count;
    assign depth_m1   = depth_reg - cnt_t'(1);
    assign top_idx    = depth_m1[NODE_W-1:0];
    assign push_idx   = depth_reg[NODE_W-1:0];
    assign top_node   = node_stack_reg[top_idx];
    assign probe      = next_stack_reg[top_idx];
    assign probe_node = probe[NODE_W-1:0];
    assign root_node  = root_reg[NODE_W-1:0];
    assign probe_end  = (probe >= live_n);
    assign probe_edge = adj_reg[top_node][probe_node];
    assign push_ok    = (depth_reg < cnt_t'(MAX_NODES));
    // edge to a node not yet seen: descend into it
    assign push_child = cmd.step && !probe_end && probe_edge
                        && !on_path_reg[probe_node] && !visited_reg[probe_node] && push_ok;

    assign status.root_end     = (root_reg >= live_n);
    assign status.root_visited = visited_reg[root_node];
    assign status.path_empty   = (depth_reg == '0);
    assign status.hit          = !probe_end && probe_edge && on_path_reg[probe_node];
    assign status.out_full     = out_valid_reg && !m_tready;

    assign m_tvalid    = out_valid_reg;
    assign cycle_found = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                adj_reg[i] <= '0;
            end
            visited_reg   <= '0;
            on_path_reg   <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_row) begin
                adj_reg[row_node] <= row_edges;
            end
            if (cmd.publish) begin
                for (int i = 0; i < MAX_NODES; i++) begin
                    adj_reg[i] <= '0;
                end
                visited_reg   <= '0;
                on_path_reg   <= '0;
                depth_reg     <= '0;
                out_valid_reg <= 1'b1;
            end else begin
                if (m_tready) begin
                    out_valid_reg <= 1'b0;
                end
                if (cmd.push_root && push_ok) begin
                    visited_reg[root_node] <= 1'b1;
                    on_path_reg[root_node] <= 1'b1;
                    depth_reg              <= depth_reg + cnt_t'(1);
                end
                if (cmd.step) begin
                    if (probe_end) begin
                        // all neighbors done: pop
                        on_path_reg[top_node] <= 1'b0;
                        depth_reg             <= depth_m1;
                    end else if (push_child) begin
                        visited_reg[probe_node] <= 1'b1;
                        on_path_reg[probe_node] <= 1'b1;
                        depth_reg               <= depth_reg + cnt_t'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_root && push_ok) begin
            node_stack_reg[push_idx] <= root_node;
            next_stack_reg[push_idx] <= '0;
        end
        if (cmd.step && !probe_end) begin
            next_stack_reg[top_idx] <= probe + cnt_t'(1);
            if (push_child) begin
                node_stack_reg[push_idx] <= probe_node;
                next_stack_reg[push_idx] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search_init) begin
            root_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            if (cmd.root_inc) begin
                root_reg <= root_reg + cnt_t'(1);
            end
            if (cmd.step && status.hit) begin
                found_reg <= 1'b1;
            end
        end
        if (cmd.publish) begin
            out_data_reg <= found_reg;
        end
    end

`include "wait_for_graph_cycle_detect_assert.svh"

    `WFGCD_ASSERT_ALWAYS(a_path_in_visited, (on_path_reg & ~visited_reg) == '0, "path node not visited")
    `WFGCD_ASSERT_ALWAYS(a_path_count, $countones(on_path_reg) == int'(depth_reg), "path marks vs depth")
    `WFGCD_ASSERT_IMPLY(a_step_nonempty, cmd.step, depth_reg != '0, "step on empty path")
    `WFGCD_ASSERT_NEXT(a_clear_after_publish, cmd.publish, visited_reg == '0 && depth_reg == '0, "graph not cleared")

endmodule

@@ hw/rtl/wait_for_graph_cycle_detect.sv @@
// ----------------------------------------------------------------------------
// wait_for_graph_cycle_detect
// Deadlock detector: depth-first cycle search over a loaded wait-for graph.
// ----------------------------------------------------------------------------
// Rows of the wait-for matrix are streamed in one word per cycle while the
// block is idle; the word with tlast set loads its row and starts the
// search. The search probes one edge per cycle on the adjacency registers:
// each root is tested or pushed, each search tree ends once its path is
// empty, each node on the path probes its n candidate edges and is then
// popped, and the end of the root scan and the hand-off follow, for a frame
// of n live nodes. The search ends early when a cycle is found, and the
// hand-off waits while an earlier answer still waits on m_. The answer is
// one word on m_ (bit 0 set means deadlock); the matrix is then cleared, so
// rows not sent in a frame carry no edges. node_count sits at byte address 0
// and may be written only while the block is idle.
// ----------------------------------------------------------------------------
module wait_for_graph_cycle_detect
    import wfgcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // row input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] row_node, [19:4] row_edges, rest zero
    input  logic        s_tlast,   // last_row
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] cycle_found, rest zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_NODE_COUNT = 1'b0;

    cnt_t          node_count_reg;
    wfgcd_cmd_t    cmd;
    wfgcd_status_t status;
    logic          cycle_found;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NODE_COUNT) ? {{(32-CNT_W){1'b0}}, node_count_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= cnt_t'(MAX_NODES);
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_NODE_COUNT)) begin
            node_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    assign m_tdata = {7'b0, cycle_found};

    wfgcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wfgcd_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .row_node    (s_tdata[3:0]),
        .row_edges   (s_tdata[19:4]),
        .node_count  (node_count_reg),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .cycle_found (cycle_found)
    );

endmodule

@@ test/wait_for_graph_cycle_detect_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wait_for_graph_cycle_detect_tb
// Streams wait-for matrix rows into the deadlock detector and checks each
// verdict word against a local depth-first search over the same rows, or
// against a verdict given in the table. A short table of hand-picked graphs
// comes first, then random frames under several node counts and several
// patterns of sender gaps and receiver stalls.
module wait_for_graph_cycle_detect_tb;
    import wfgcd_pkg::*;

    localparam logic [2:0] NODE_COUNT_ADDR = 3'd0;
    localparam logic [2:0] SPARE_ADDR      = 3'd4;   // no register behind it
    localparam int SETTLE_CYCLES   = 320;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 8;
    localparam int CYCLE_LIMIT     = 3_000_000;

    typedef enum int {ROWS_DAG, ROWS_SPARSE, ROWS_DENSE, ROWS_THIN} row_shape_t;

    typedef struct packed {
        bit         is_cfg;
        logic [2:0] addr;
        logic [31:0] value;
        node_t      node;
        mask_t      edges;
        bit         last;
        bit         typed;
        bit         deadlock;
    } plan_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;     // [3:0] row_node, [19:4] row_edges, rest zero
    logic        s_tlast  = 1'b0;   // last_row
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [0] cycle_found, rest zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // local copy of the block's state
    mask_t wait_rows [MAX_NODES];
    cnt_t  live_count = cnt_t'(16);

    bit    pending_verdicts [$];
    int    mismatches     = 0;
    int    cycles         = 0;
    int    send_idle_pct  = 0;
    int    recv_stall_pct = 0;
    logic [7:0] want_word;

    plan_row_t plan [0:25] = '{
        // empty graph right after reset
        '{1'b0, 3'd0, 32'd0, 4'd0,  16'h0000, 1'b1, 1'b1, 1'b0},
        // self-loop
        '{1'b0, 3'd0, 32'd0, 4'd5,  16'h0020, 1'b1, 1'b1, 1'b1},
        // all-ones row on the top node carries a self-loop
        '{1'b0, 3'd0, 32'd0, 4'd15, 16'hFFFF, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd0,  16'h0000, 1'b1, 1'b1, 1'b1},
        // 0 -> 1 -> 2 -> 0
        '{1'b0, 3'd0, 32'd0, 4'd0,  16'h0002, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd1,  16'h0004, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd2,  16'h0001, 1'b1, 1'b1, 1'b1},
        // plain chain, no cycle
        '{1'b0, 3'd0, 32'd0, 4'd0,  16'h0002, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd1,  16'h0004, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd2,  16'h0000, 1'b1, 1'b1, 1'b0},
        // repeated row replaces the self-loop
        '{1'b0, 3'd0, 32'd0, 4'd3,  16'h0008, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd3,  16'h0000, 1'b1, 1'b1, 1'b0},
        // two-node cycle on the top indexes
        '{1'b0, 3'd0, 32'd0, 4'd14, 16'h8000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd15, 16'h4000, 1'b1, 1'b1, 1'b1},
        // alternating masks, left to the predictor
        '{1'b0, 3'd0, 32'd0, 4'd7,  16'hAAAA, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd8,  16'h5555, 1'b1, 1'b0, 1'b0},
        // two live nodes: edges to node 3 and its self-loop are ignored
        '{1'b1, NODE_COUNT_ADDR, 32'd2, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd1,  16'h0008, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd3,  16'h0008, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd0,  16'h0002, 1'b1, 1'b1, 1'b0},
        // zero live nodes: nothing is searched
        '{1'b1, NODE_COUNT_ADDR, 32'd0, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd0,  16'h0001, 1'b1, 1'b1, 1'b0},
        // count above the matrix size saturates
        '{1'b1, NODE_COUNT_ADDR, 32'd31, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd15, 16'h8000, 1'b1, 1'b1, 1'b1},
        // write to an unmapped address leaves the count alone
        '{1'b1, SPARE_ADDR, 32'd1, 4'd0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd0, 32'd0, 4'd15, 16'h8000, 1'b1, 1'b1, 1'b1}
    };

    wait_for_graph_cycle_detect u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    function automatic void clear_rows();
        foreach (wait_rows[i]) wait_rows[i] = '0;
    endfunction

    // iterative DFS with an explicit path; an edge back onto the path is a cycle
    function automatic bit find_deadlock();
        mask_t visited;
        mask_t on_path;
        node_t path_node [MAX_NODES];
        cnt_t  path_next [MAX_NODES];
        int    depth;
        int    n;
        int    v;
        int    u;
        n = (live_count > MAX_NODES) ? MAX_NODES : int'(live_count);
        visited = '0;
        on_path = '0;
        for (int root = 0; root < n; root++) begin
            if (visited[root])
                continue;
            visited[root] = 1'b1;
            on_path[root] = 1'b1;
            path_node[0] = node_t'(root);
            path_next[0] = '0;
            depth = 1;
            while (depth > 0) begin
                v = path_node[depth-1];
                u = path_next[depth-1];
                if (u >= n) begin
                    on_path[v] = 1'b0;
                    depth--;
                end else begin
                    path_next[depth-1] = cnt_t'(u + 1);
                    if (wait_rows[v][u]) begin
                        if (on_path[u])
                            return 1'b1;
                        if (!visited[u]) begin
                            visited[u] = 1'b1;
                            on_path[u] = 1'b1;
                            path_node[depth] = node_t'(u);
                            path_next[depth] = '0;
                            depth++;
                        end
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic send_row(input node_t node, input mask_t edges, input bit last,
                            output bit has_verdict, output bit deadlock);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, edges, node};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        wait_rows[node] = edges;
        has_verdict = last;
        deadlock = 1'b0;
        if (last) begin
            deadlock = find_deadlock();
            clear_rows();
        end
    endtask

    // stop sending, let every verdict arrive, then let a search still running finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == NODE_COUNT_ADDR)
            live_count = data[CNT_W-1:0];
    endtask

    task automatic run_frames(input int items_wanted);
        int         sent;
        int         rows;
        int         live;
        row_shape_t shape;
        node_t      nd;
        mask_t      ed;
        bit         has_verdict;
        bit         deadlock;
        live = (live_count > MAX_NODES) ? MAX_NODES : int'(live_count);
        sent = 0;
        while (sent < items_wanted) begin
            rows  = $urandom_range(1, live + 2);
            shape = row_shape_t'($urandom_range(0, 3));
            for (int i = 0; i < rows; i++) begin
                // mostly live nodes, now and then any row
                if (live == 0 || $urandom_range(9) == 0)
                    nd = node_t'($urandom_range(0, MAX_NODES - 1));
                else
                    nd = node_t'($urandom_range(0, live - 1));
                case (shape)
                    ROWS_DAG: begin
                        // forward edges only, with an occasional back edge
                        ed = mask_t'($urandom & ~((32'd2 << nd) - 1));
                        if ($urandom_range(9) == 0)
                            ed[$urandom_range(0, nd)] = 1'b1;
                    end
                    ROWS_SPARSE: begin
                        ed = ($urandom_range(2) == 0) ? '0 :
                             mask_t'(16'h1 << $urandom_range(0, MAX_NODES - 1));
                    end
                    ROWS_DENSE: ed = mask_t'($urandom);
                    default:    ed = mask_t'($urandom & $urandom & $urandom);
                endcase
                send_row(nd, ed, i == rows - 1, has_verdict, deadlock);
                if (has_verdict)
                    pending_verdicts.push_back(deadlock);
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word %h arrived with none pending", m_tdata);
            end else begin
                want_word = {7'b0, pending_verdicts.pop_front()};
                if (m_tdata !== want_word) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("verdict mismatch: expected %h, got %h", want_word, m_tdata);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin : stimulus
        bit has_verdict;
        bit deadlock;
        int count;
        clear_rows();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < $size(plan); k++) begin
            if (plan[k].is_cfg) begin
                drain();
                apb_write(plan[k].addr, plan[k].value);
            end else begin
                send_row(plan[k].node, plan[k].edges, plan[k].last, has_verdict, deadlock);
                if (has_verdict)
                    pending_verdicts.push_back(plan[k].typed ? plan[k].deadlock : deadlock);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0, 7:    count = 16;
                1:       count = 1;
                2:       count = 8;
                3:       count = 0;
                4:       count = 17;
                5:       count = 2;
                default: count = $urandom_range(3, 15);
            endcase
            drain();
            apb_write(NODE_COUNT_ADDR, 32'(count));
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            run_frames(ITEMS_PER_PHASE);
        end

        drain();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
